>>> rtl/core/multi_client_silence_watchdog_unit_defines.svh
// Assertion macros used by the back part of the silence watchdog RTL.
`ifndef MULTI_CLIENT_SILENCE_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_CLIENT_SILENCE_WATCHDOG_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define MCSW_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("watchdog assertion failed");
// Check a property on every rising clock edge, reset included.
`define MCSW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("watchdog assertion failed");
`else
`define MCSW_ASSERT(name, clk, rstn, prop)
`define MCSW_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> rtl/core/mcsw_pkg.sv
// Types and constants of the silence watchdog.
package mcsw_pkg;

  localparam int ClientW     = 7;
  localparam int CountW      = 16;
  localparam int LevelW      = 2;
  localparam int RegIdxW     = 2;
  localparam int ClientSpan  = 1 << ClientW;
  localparam int QueueDepth  = 2;
  localparam int QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [CountW-1:0] CountMax      = '1;
  localparam logic [CountW-1:0] WarnReset     = 16'd300;
  localparam logic [CountW-1:0] SevereReset   = 16'd900;
  localparam logic [CountW-1:0] CriticalReset = 16'd1500;

  typedef enum logic {
    CMD_MESSAGE = 1'b0,
    CMD_POLL    = 1'b1
  } cmd_e;

  typedef enum logic [LevelW-1:0] {
    LEVEL_NONE     = 2'd0,
    LEVEL_WARN     = 2'd1,
    LEVEL_SEVERE   = 2'd2,
    LEVEL_CRITICAL = 2'd3
  } level_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_WARN     = 2'd0,
    REG_SEVERE   = 2'd1,
    REG_CRITICAL = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               in_range;
    logic [ClientW-1:0] client;
    logic               at_rest;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] warn;
    logic [CountW-1:0] severe;
    logic [CountW-1:0] critical;
  } thresh_t;

  typedef struct packed {
    logic              heard;
    logic [CountW-1:0] count;
    level_e            level;
    logic              rest;
  } entry_t;

  localparam entry_t EntryReset = '{heard: 1'b0, count: '0, level: LEVEL_NONE, rest: 1'b1};

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/core/multi_client_silence_watchdog_unit.sv
// Silence watchdog: per-client silence counter with escalating alert levels.
// Each item does a read then a write of the client table through its registered read
// port, so no new item begins until the last is written; a 2-entry queue lets start be
// taken while one works. Reset: thresholds return to 300, 900 and 1500 and every
// client entry reads as cleared at once through per-entry valid bits; no clearing
// pass. Results cannot be stalled.
module multi_client_silence_watchdog_unit import mcsw_pkg::*; #(
  parameter int CLIENTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [ClientW-1:0] client_i,
  input  logic               at_rest_i,
  output logic               result_strobe_o,
  output logic [ClientW-1:0] client_out_o,
  output logic [LevelW-1:0]  alert_level_o,
  output logic [CountW-1:0]  silent_seconds_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  thresh_t       thresh_q, thresh_d;
  queue_status_t queue_status;
  logic          push;
  item_t         push_data;
  logic          pop;
  item_t         head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_WARN:     thresh_d.warn     = cfg_data_i;
        REG_SEVERE:   thresh_d.severe   = cfg_data_i;
        REG_CRITICAL: thresh_d.critical = cfg_data_i;
        default:      thresh_d = thresh_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '{warn: WarnReset, severe: SevereReset, critical: CriticalReset};
    end else begin
      thresh_q <= thresh_d;
    end
  end

  mcsw_front #(
    .CLIENTS(CLIENTS)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .client_i      (client_i),
    .at_rest_i     (at_rest_i),
    .queue_status_i(queue_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  mcsw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (head),
    .status_o   (queue_status)
  );

  mcsw_back #(
    .CLIENTS(CLIENTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .thresh_i        (thresh_q),
    .queue_status_i  (queue_status),
    .head_i          (head),
    .pop_o           (pop),
    .result_strobe_o (result_strobe_o),
    .client_out_o    (client_out_o),
    .alert_level_o   (alert_level_o),
    .silent_seconds_o(silent_seconds_o)
  );

endmodule

>>> rtl/core/mcsw_fifo.sv
// Two-entry item queue between the front and back parts of the watchdog.
module mcsw_fifo import mcsw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  item_t         push_data_i,
  input  logic          pop_i,
  output item_t         pop_data_o,
  output queue_status_t status_o
);

  localparam int PtrW = $clog2(QueueDepth);

  item_t                entries_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = entries_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> rtl/core/mcsw_front.sv
// Front part: takes commands, checks the client range and queues the item.
module mcsw_front import mcsw_pkg::*; #(
  parameter int CLIENTS = 128
) (
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [ClientW-1:0] client_i,
  input  logic               at_rest_i,
  input  queue_status_t      queue_status_i,
  output logic               push_o,
  output item_t              push_data_o
);

  assign busy   = queue_status_i.full;
  assign push_o = start && !queue_status_i.full;

  always_comb begin
    push_data_o.cmd      = cmd_e'(cmd_i);
    // Clients past the configured count leave all state alone.
    push_data_o.in_range = ({{(32 - ClientW){1'b0}}, client_i} < 32'(CLIENTS));
    push_data_o.client   = client_i;
    push_data_o.at_rest  = at_rest_i;
  end

endmodule

>>> rtl/core/mcsw_back.sv
// Back part: read-modify-write of the per-client table and result register.
`include "multi_client_silence_watchdog_unit_defines.svh"

module mcsw_back import mcsw_pkg::*; #(
  parameter int CLIENTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  thresh_t            thresh_i,
  input  queue_status_t      queue_status_i,
  input  item_t              head_i,
  output logic               pop_o,
  output logic               result_strobe_o,
  output logic [ClientW-1:0] client_out_o,
  output logic [LevelW-1:0]  alert_level_o,
  output logic [CountW-1:0]  silent_seconds_o
);

  localparam int Depth = (CLIENTS < ClientSpan) ? CLIENTS : ClientSpan;
  localparam int AddrW = $clog2(Depth);

  back_state_e        state_q, state_d;
  item_t              item_q;
  entry_t             mem [Depth];
  entry_t             rdata_q;
  logic               rvld_q;
  logic [Depth-1:0]   vld_q;
  logic               rd_en;
  logic               wr_en;
  logic [AddrW-1:0]   rd_addr;
  logic [AddrW-1:0]   wr_addr;
  entry_t             cur;
  entry_t             nxt;
  logic [CountW-1:0]  cnt_inc;
  logic               strobe_q;
  logic [ClientW-1:0] client_q;
  logic [LevelW-1:0]  level_q;
  logic [CountW-1:0]  count_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!queue_status_i.empty) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o = 1'b0;
    wr_en = 1'b0;
    unique case (state_q)
      S_IDLE: pop_o = !queue_status_i.empty;
      S_EXEC: wr_en = item_q.in_range;
      default: begin
        pop_o = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_en   = pop_o && head_i.in_range;
  assign rd_addr = head_i.client[AddrW-1:0];
  assign wr_addr = item_q.client[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == S_EXEC);
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= vld_q[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= nxt;
    end
  end

  // Entries never written read as their reset value.
  assign cur     = rvld_q ? rdata_q : EntryReset;
  assign cnt_inc = (cur.count == CountMax) ? cur.count : cur.count + 1'b1;

  always_comb begin
    nxt = cur;
    if (item_q.cmd == CMD_MESSAGE) begin
      nxt.heard = 1'b1;
      nxt.rest  = item_q.at_rest;
    end else begin
      if (!cur.rest) begin
        if (cur.heard) begin
          nxt.count = '0;
        end else begin
          nxt.count = cnt_inc;
          priority if (cnt_inc < thresh_i.warn) begin
            nxt.level = LEVEL_NONE;
          end else if (cnt_inc == thresh_i.warn) begin
            nxt.level = LEVEL_WARN;
          end else if (cnt_inc == thresh_i.severe) begin
            nxt.level = LEVEL_SEVERE;
          end else if (cnt_inc == thresh_i.critical) begin
            nxt.level = LEVEL_CRITICAL;
          end else begin
            nxt.level = cur.level;
          end
        end
      end
      nxt.heard = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      client_q <= item_q.client;
      level_q  <= item_q.in_range ? nxt.level : LEVEL_NONE;
      count_q  <= item_q.in_range ? nxt.count : '0;
    end
  end

  assign result_strobe_o  = strobe_q;
  assign client_out_o     = client_q;
  assign alert_level_o    = level_q;
  assign silent_seconds_o = count_q;

  `MCSW_ASSERT(a_strobe_after_exec, clk_i, rst_ni, result_strobe_o |-> $past(state_q == S_EXEC))
  `MCSW_ASSERT(a_write_after_read, clk_i, rst_ni, wr_en |-> $past(pop_o))
  `MCSW_ASSERT(a_single_exec, clk_i, rst_ni, (state_q == S_EXEC) |=> (state_q == S_IDLE))
  `MCSW_ASSERT_ALWAYS(a_pop_nonempty, clk_i, pop_o |-> !queue_status_i.empty)

endmodule

>>> bench/silence_watch_checker.sv
// Checker for the silence watchdog: tracks per-client state and compares every result.
`timescale 1ns / 1ps

module silence_watch_checker import mcsw_pkg::*; #(
  parameter int CLIENTS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cmd_i,
  input  logic [ClientW-1:0] client_i,
  input  logic               at_rest_i,
  input  logic               strobe_i,
  input  logic [ClientW-1:0] client_out_i,
  input  logic [LevelW-1:0]  alert_level_i,
  input  logic [CountW-1:0]  silent_seconds_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [ClientW-1:0] client;
    level_e             level;
    logic [CountW-1:0]  count;
  } client_report_t;

  logic [CountW-1:0] warn_q;
  logic [CountW-1:0] severe_q;
  logic [CountW-1:0] critical_q;

  logic              heard_tbl [CLIENTS];
  logic [CountW-1:0] count_tbl [CLIENTS];
  level_e            level_tbl [CLIENTS];
  logic              rest_tbl  [CLIENTS];

  client_report_t expected_reports [$];
  int mismatches = 0;
  int checked = 0;

  assign mismatches_o = mismatches;
  assign checked_o    = checked;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) begin
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Apply one transaction to the client table and return the report it should produce.
  function automatic client_report_t track_item(cmd_e cmd, logic [ClientW-1:0] cl, logic rest);
    client_report_t r;
    r.client = cl;
    r.level  = LEVEL_NONE;
    r.count  = '0;
    if (int'(cl) >= CLIENTS) begin
      return r;
    end
    if (cmd == CMD_MESSAGE) begin
      heard_tbl[cl] = 1'b1;
      rest_tbl[cl]  = rest;
    end else begin
      if (!rest_tbl[cl]) begin
        if (heard_tbl[cl]) begin
          count_tbl[cl] = '0;
        end else begin
          if (count_tbl[cl] != CountMax) count_tbl[cl] = count_tbl[cl] + 1'b1;
          // order matters when thresholds overlap: below-warn first, then equalities
          if (count_tbl[cl] < warn_q) level_tbl[cl] = LEVEL_NONE;
          else if (count_tbl[cl] == warn_q) level_tbl[cl] = LEVEL_WARN;
          else if (count_tbl[cl] == severe_q) level_tbl[cl] = LEVEL_SEVERE;
          else if (count_tbl[cl] == critical_q) level_tbl[cl] = LEVEL_CRITICAL;
        end
      end
      heard_tbl[cl] = 1'b0;
    end
    r.level = level_tbl[cl];
    r.count = count_tbl[cl];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_seq
    client_report_t want;
    if (!rst_ni) begin
      warn_q     <= WarnReset;
      severe_q   <= SevereReset;
      critical_q <= CriticalReset;
      for (int i = 0; i < CLIENTS; i++) begin
        heard_tbl[i] = 1'b0;
        count_tbl[i] = '0;
        level_tbl[i] = LEVEL_NONE;
        rest_tbl[i]  = 1'b1;
      end
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      // compare first: a result never belongs to the transaction taken at this edge
      if (strobe_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing outstanding, client", 32'(client_out_i), 0);
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (client_out_i !== want.client) begin
            report_mismatch("client_out", 32'(client_out_i), 32'(want.client));
          end
          if (alert_level_i !== want.level) begin
            report_mismatch("alert_level", 32'(alert_level_i), 32'(want.level));
          end
          if (silent_seconds_i !== want.count) begin
            report_mismatch("silent_seconds", 32'(silent_seconds_i), 32'(want.count));
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_reports.push_back(track_item(cmd_e'(cmd_i), client_i, at_rest_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_WARN:     warn_q     <= cfg_data_i;
          REG_SEVERE:   severe_q   <= cfg_data_i;
          REG_CRITICAL: critical_q <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_reports.size();
    end
  end

endmodule

>>> bench/tb.sv
// Testbench top for the silence watchdog: stimulus, timeout guard and verdict.
`timescale 1ns / 1ps

module tb import mcsw_pkg::*;;

  localparam int StallLimit = 2000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cmd_i = 1'b0;
  logic [ClientW-1:0] client_i = '0;
  logic               at_rest_i = 1'b0;
  logic               result_strobe_o;
  logic [ClientW-1:0] client_out_o;
  logic [LevelW-1:0]  alert_level_o;
  logic [CountW-1:0]  silent_seconds_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [RegIdxW-1:0] cfg_index_i = '0;
  logic [CountW-1:0]  cfg_data_i = '0;

  int mismatches;
  int pending;
  int checked;
  int items_sent = 0;
  int cfg_writes = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  multi_client_silence_watchdog_unit #(.CLIENTS(128)) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .client_i         (client_i),
    .at_rest_i        (at_rest_i),
    .result_strobe_o  (result_strobe_o),
    .client_out_o     (client_out_o),
    .alert_level_o    (alert_level_o),
    .silent_seconds_o (silent_seconds_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  silence_watch_checker #(.CLIENTS(128)) watch_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_i),
    .client_i         (client_i),
    .at_rest_i        (at_rest_i),
    .strobe_i         (result_strobe_o),
    .client_out_i     (client_out_o),
    .alert_level_i    (alert_level_o),
    .silent_seconds_i (silent_seconds_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort when no transaction of any kind moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Hold start until the transaction is taken, then maybe drop start for a random pause.
  task automatic send_item(cmd_e cmd, logic [ClientW-1:0] cl, logic rest);
    start     <= 1'b1;
    cmd_i     <= cmd;
    client_i  <= cl;
    at_rest_i <= rest;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_for_results();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [CountW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
  endtask

  // Write all three thresholds plus the unused index, which must be ignored.
  task automatic load_thresholds(logic [CountW-1:0] w, logic [CountW-1:0] s,
                                 logic [CountW-1:0] c);
    reg_write(REG_WARN, w);
    reg_write(REG_SEVERE, s);
    reg_write(REG_CRITICAL, c);
    reg_write(REG_UNUSED, CountW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int target, int pct);
    logic [ClientW-1:0] hot [4];
    logic [ClientW-1:0] cl;
    int sent;
    int pauses;
    idle_pct = pct;
    sent = 0;
    pauses = 0;
    foreach (hot[i]) hot[i] = ClientW'($urandom_range(0, ClientSpan - 1));
    while (sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any client, any command
        send_item(cmd_e'($urandom_range(0, 1)), ClientW'($urandom_range(0, ClientSpan - 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        // burst: start tracking a client, then let it go silent
        cl = hot[$urandom_range(0, 3)];
        send_item(CMD_MESSAGE, cl, $urandom_range(0, 9) == 0);
        sent++;
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 7) == 0) send_item(CMD_MESSAGE, cl, $urandom_range(0, 5) == 0);
          else send_item(CMD_POLL, cl, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if (sent / 60 != pauses) begin
        pauses = sent / 60;
        wait_for_results();
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: rest flags start set, heard flag clears an en-route count
    send_item(CMD_POLL, 7'd0, 1'b0);
    send_item(CMD_MESSAGE, 7'd0, 1'b0);
    send_item(CMD_POLL, 7'd0, 1'b0);
    send_item(CMD_POLL, 7'd0, 1'b0);
    send_item(CMD_POLL, 7'd0, 1'b1);
    send_item(CMD_MESSAGE, 7'd127, 1'b1);
    send_item(CMD_POLL, 7'd127, 1'b0);
    send_item(CMD_MESSAGE, 7'd127, 1'b0);
    send_item(CMD_POLL, 7'd127, 1'b1);
    send_item(CMD_POLL, 7'd127, 1'b0);
    drain();

    // climb through every level, then heard-while-en-route keeps the level
    load_thresholds(16'd2, 16'd4, 16'd6);
    send_item(CMD_MESSAGE, 7'd5, 1'b0);
    repeat (8) send_item(CMD_POLL, 7'd5, 1'b0);
    send_item(CMD_MESSAGE, 7'd5, 1'b0);
    send_item(CMD_POLL, 7'd5, 1'b0);
    send_item(CMD_POLL, 7'd5, 1'b0);
    send_item(CMD_MESSAGE, 7'd5, 1'b1);
    send_item(CMD_POLL, 7'd5, 1'b0);
    drain();

    load_thresholds(16'($urandom_range(1, 4)), 16'($urandom_range(2, 8)),
                    16'($urandom_range(3, 12)));
    run_phase(170, 12);
    load_thresholds(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                    16'($urandom_range(1, 12)));
    run_phase(170, 47);
    load_thresholds(16'd1, 16'($urandom_range(1, 10)), 16'hFFFF);
    run_phase(170, 0);

    $display("Ran %0d items with %0d results checked and %0d register writes",
             items_sent, checked, cfg_writes);
    $display("Included level climbs, at-rest and heard cases, mixed idle rates");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mcsw_pkg.sv
rtl/core/mcsw_fifo.sv
rtl/core/mcsw_front.sv
rtl/core/mcsw_back.sv
rtl/core/multi_client_silence_watchdog_unit.sv
bench/silence_watch_checker.sv
bench/tb.sv
